@@ hw/rtl/qapm_pkg.sv @@
// ----------------------------------------------------------------------------
// qapm_pkg
// constants and types shared by the attitude pid and motor mixer
// ----------------------------------------------------------------------------
package qapm_pkg;

    localparam int ACC_W = 48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_OUT
    } t_state;

    localparam logic [2:0] CFG_ROLL  = 3'd0;
    localparam logic [2:0] CFG_PITCH = 3'd1;
    localparam logic [2:0] CFG_YAW   = 3'd2;
    localparam logic [2:0] CFG_TRIM  = 3'd3;
    localparam logic [2:0] CFG_ARMED = 3'd4;

    localparam logic [11:0] THR_BASE  = 12'd1000;
    localparam logic [11:0] YAW_LO    = 12'd1480;
    localparam logic [11:0] YAW_HI    = 12'd1520;
    localparam logic [11:0] YAW_MID   = 12'd1500;

endpackage

@@ hw/rtl/quad_attitude_pid_mixer.sv @@
// ----------------------------------------------------------------------------
// quad_attitude_pid_mixer
// x-frame roll/pitch/yaw pid with four-motor mix, bit-serial multiplier
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// in        in   i_valid / o_ready      angles, targets, sticks, gyro rates
// out       out  o_valid / i_ready      four motors, yaw integral clear
// cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one item runs 8 products of 16 serial steps each on the shared shift-add multiplier, then an output step
// synchronous active-low reset clears control, config registers and integrals
// a new item is taken while the previous result waits in the output register
// the output cycle holds until that earlier result has been transferred
// ----------------------------------------------------------------------------
module quad_attitude_pid_mixer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic signed [15:0] i_roll_angle,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_yaw_angle,
    input  logic signed [15:0] i_roll_target,
    input  logic signed [15:0] i_pitch_target,
    input  logic signed [15:0] i_yaw_target,
    input  logic [11:0] i_throttle_stick,
    input  logic [11:0] i_yaw_stick,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_motor_one,
    output logic [15:0] o_motor_two,
    output logic [15:0] o_motor_three,
    output logic [15:0] o_motor_four,
    output logic        o_yaw_rate_integral_clear,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    import qapm_pkg::*;

    logic [47:0] r_roll_gains, r_pitch_gains, r_trim;
    logic [31:0] r_yaw_gains;
    logic        r_armed;
    logic signed [31:0] r_roll_int, r_pitch_int;

    t_state r_state, n_state;
    logic [2:0] r_prod;
    logic [3:0] r_bit;

    // captured operands
    logic signed [16:0] r_rol, r_pit, r_yaw;
    logic signed [16:0] r_gx, r_gy;
    logic signed [17:0] r_yrate;
    logic [11:0] r_thr;
    logic        r_upd, r_clr_int, r_yclr;

    // serial multiplier: unsigned 16-bit gain times signed operand
    logic [15:0] r_mplier;
    logic signed [ACC_W-1:0] r_mcand, r_acc;
    logic signed [ACC_W-1:0] r_rout, r_pout, r_yout;

    logic [15:0] r_m1, r_m2, r_m3, r_m4;
    logic        r_oyclr;
    logic        r_ovalid;

    assign o_cfg_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign o_ready     = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_valid     = r_ovalid;
    assign o_motor_one   = r_m1;
    assign o_motor_two   = r_m2;
    assign o_motor_three = r_m3;
    assign o_motor_four  = r_m4;
    assign o_yaw_rate_integral_clear = r_oyclr;

    // item setup
    logic signed [12:0] thr_full;
    logic [11:0] thr_in;
    logic [12:0] ys_diff;
    logic signed [17:0] yr_in;
    logic        ycl_in, lvl_in;

    always_comb begin
        thr_full = $signed({1'b0, i_throttle_stick}) - $signed({1'b0, THR_BASE});
        thr_in   = thr_full[12] ? 12'd0 : thr_full[11:0];
        ycl_in   = (i_yaw_stick < YAW_LO) || (i_yaw_stick > YAW_HI);
        ys_diff  = {1'b0, i_yaw_stick} - {1'b0, YAW_MID};
        yr_in    = ycl_in ? (18'(signed'(i_gyro_z))
                    + 18'($signed(ys_diff)) * 18'sd10) : 18'(signed'(i_gyro_z));
        lvl_in   = (i_roll_target > -16'sd64) && (i_roll_target < 16'sd64)
                && (i_pitch_target > -16'sd64) && (i_pitch_target < 16'sd64)
                && (i_roll_angle > -16'sd640) && (i_roll_angle < 16'sd640)
                && (i_pitch_angle > -16'sd640) && (i_pitch_angle < 16'sd640)
                && (thr_in > 12'd300);
    end

    // operand selection per product
    logic [15:0] sel_g;
    logic signed [ACC_W-1:0] sel_x;
    always_comb begin
        case (r_prod)
            3'd0: begin sel_g = r_roll_gains[15:0];  sel_x = ACC_W'(r_rol); end
            3'd1: begin sel_g = r_roll_gains[31:16]; sel_x = ACC_W'(r_rol); end
            3'd2: begin sel_g = r_roll_gains[47:32]; sel_x = ACC_W'(r_gx) <<< 6; end
            3'd3: begin sel_g = r_pitch_gains[15:0]; sel_x = ACC_W'(r_pit); end
            3'd4: begin sel_g = r_pitch_gains[31:16]; sel_x = ACC_W'(r_pit); end
            3'd5: begin sel_g = r_pitch_gains[47:32]; sel_x = ACC_W'(r_gy) <<< 6; end
            3'd6: begin sel_g = r_yaw_gains[15:0];   sel_x = ACC_W'(r_yaw); end
            default: begin sel_g = r_yaw_gains[31:16]; sel_x = ACC_W'(r_yrate) <<< 6; end
        endcase
    end

    // integral update after its product lands
    logic signed [ACC_W-1:0] imax, ri_sum, pi_sum, ri_new, pi_new, prod_done;
    logic [24:0] lim_prod;
    logic [10:0] lim_int;
    always_comb begin
        prod_done = r_acc + (r_mplier[0] ? r_mcand : '0);
        // divide by ten through a reciprocal multiply
        lim_prod = 25'(r_thr) * 25'd6554;
        lim_int = 11'(lim_prod >> 16);
        imax = ACC_W'(lim_int) <<< 14;
        ri_sum = ACC_W'(r_roll_int) + prod_done;
        pi_sum = ACC_W'(r_pitch_int) + prod_done;
        ri_new = (ri_sum > imax) ? imax : ((ri_sum < -imax) ? -imax : ri_sum);
        pi_new = (pi_sum > imax) ? imax : ((pi_sum < -imax) ? -imax : pi_sum);
    end

    // mixing
    logic signed [ACC_W-1:0] q_h, z_y, x_z, bse, ro, po, yo;
    logic signed [ACC_W-1:0] mx1, mx2, mx3, mx4;
    logic run;
    function automatic logic [15:0] sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v >>> 14;
        if (v < 0) sat = 16'd0;
        else if (t > 48'sd65535) sat = 16'hFFFF;
        else sat = t[15:0];
    endfunction
    always_comb begin
        q_h = ACC_W'(signed'(r_trim[15:0]));
        z_y = ACC_W'(signed'(r_trim[31:16]));
        x_z = ACC_W'(signed'(r_trim[47:32]));
        bse = ACC_W'(r_thr);
        ro  = r_rout + ACC_W'(r_roll_int);
        po  = r_pout + ACC_W'(r_pitch_int);
        yo  = r_yout;
        mx1 = ((bse - 48'sd25 + q_h + z_y - x_z) <<< 14) - ro - po + yo;
        mx2 = ((bse - 48'sd25 + q_h - z_y + x_z) <<< 14) - ro + po - yo;
        mx3 = ((bse - 48'sd25 - q_h + z_y + x_z) <<< 14) + ro - po - yo;
        mx4 = ((bse + 48'sd75 - q_h - z_y - x_z) <<< 14) + ro + po + yo;
        run = (r_thr > 12'd200) && r_armed;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid && o_ready) n_state = ST_MUL;
            ST_MUL:  if (r_bit == 4'd15 && r_prod == 3'd7) n_state = ST_OUT;
            ST_OUT:  if (!r_ovalid || i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_roll_gains <= '0;
            r_pitch_gains <= '0;
            r_yaw_gains <= '0;
            r_trim <= '0;
            r_armed <= 1'b0;
            r_roll_int <= '0;
            r_pitch_int <= '0;
            r_prod <= '0;
            r_bit <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROLL:  r_roll_gains  <= i_cfg_data;
                    CFG_PITCH: r_pitch_gains <= i_cfg_data;
                    CFG_YAW:   r_yaw_gains   <= i_cfg_data[31:0];
                    CFG_TRIM:  r_trim        <= i_cfg_data;
                    CFG_ARMED: r_armed       <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_rol <= 17'(i_roll_target) + 17'(i_roll_angle);
                        r_pit <= 17'(i_pitch_target) + 17'(i_pitch_angle);
                        r_yaw <= 17'(i_yaw_target) + 17'(i_yaw_angle);
                        r_gx <= 17'(i_gyro_x);
                        r_gy <= 17'(i_gyro_y);
                        r_yrate <= yr_in;
                        r_thr <= thr_in;
                        r_upd <= lvl_in;
                        r_clr_int <= !lvl_in && (thr_in < 12'd200);
                        r_yclr <= ycl_in;
                        r_prod <= '0;
                        r_bit <= '0;
                        r_acc <= '0;
                        r_mplier <= r_roll_gains[15:0];
                        r_mcand <= ACC_W'(17'(i_roll_target) + 17'(i_roll_angle));
                    end
                end
                ST_MUL: begin
                    if (r_bit == 4'd15) begin
                        case (r_prod)
                            3'd0: r_rout <= prod_done;
                            3'd1: begin
                                if (r_upd) r_roll_int <= ri_new[31:0];
                                else if (r_clr_int) r_roll_int <= '0;
                            end
                            3'd2: r_rout <= r_rout + prod_done;
                            3'd3: r_pout <= prod_done;
                            3'd4: begin
                                if (r_upd) r_pitch_int <= pi_new[31:0];
                                else if (r_clr_int) r_pitch_int <= '0;
                            end
                            3'd5: r_pout <= r_pout + prod_done;
                            3'd6: r_yout <= prod_done;
                            default: r_yout <= r_yout + prod_done;
                        endcase
                        r_prod <= r_prod + 3'd1;
                        r_bit <= '0;
                        r_acc <= '0;
                    end else begin
                        r_acc <= prod_done;
                        r_mcand <= r_mcand <<< 1;
                        r_mplier <= r_mplier >> 1;
                        r_bit <= r_bit + 4'd1;
                    end
                end
                default: ;
            endcase
            // clear the operands when a product finishes, load the next pair on its first step
            if (r_state == ST_MUL && r_bit == 4'd15) begin
                r_mcand <= '0;
                r_mplier <= '0;
            end
            if (r_state == ST_MUL && r_bit == 4'd0) begin
                r_mplier <= sel_g >> 1;
                r_mcand <= sel_x <<< 1;
                r_acc <= sel_g[0] ? sel_x : '0;
            end
            if (r_state == ST_OUT && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
                r_oyclr <= r_yclr;
                r_m1 <= run ? sat(mx1) : 16'd0;
                r_m2 <= run ? sat(mx2) : 16'd0;
                r_m3 <= run ? sat(mx3) : 16'd0;
                r_m4 <= run ? sat(mx4) : 16'd0;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready)
        else $error("ready while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> o_valid)
        else $error("result not presented");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_armed) |-> (o_motor_one == 16'd0 && o_motor_four == 16'd0))
        else $error("motor drive while disarmed");

endmodule
